FILE: src/tple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tple_pkg
// Shared constants, request codes and controller states of the tree path
// load engine.
// ----------------------------------------------------------------------------
package tple_pkg;

    localparam int NODE_BITS_DEF   = 16;
    localparam int LIFT_LEVELS_DEF = 16;
    localparam int IN_NODE_W       = 16;
    localparam int LOAD_W          = 32;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_PATH = 2'd1,
        REQ_FIN  = 2'd2
    } req_t;

    typedef enum logic {
        STS_OK  = 1'b0,
        STS_BAD = 1'b1
    } sts_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RA,
        ST_RB,
        ST_ADD_CHK,
        ST_ADD_LR,
        ST_ADD_LW,
        ST_P_CHK,
        ST_P_L1,
        ST_P_L1W,
        ST_P_EQ,
        ST_P_L2A,
        ST_P_L2B,
        ST_P_L2C,
        ST_P_L2F,
        ST_P_L2G,
        ST_P_PP,
        ST_P_PPW,
        ST_P_UR,
        ST_P_UW,
        ST_F_R0,
        ST_F_X,
        ST_F_C,
        ST_F_W,
        ST_G_R,
        ST_G_X,
        ST_G_W
    } state_t;

endpackage

FILE: src/tree_path_load_lca_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_load_lca_engine_unit
// Rooted tree in RAM: node insertion with binary-lifting ancestors, lowest
// common ancestor queries with path difference counts, and a finish pass
// that folds counts into parents and reports the largest node load.
//
// Usage: drive req_type, node_a and node_b and raise start while busy is low;
// the word is taken at that edge. Exactly one result word follows, shown for
// one cycle with done high on ancestor_node, max_load and status. The
// receiver cannot stall; busy stays high until done, and the next word may be
// taken in the cycle that done is shown.
// Path queries make two ancestor reads per level through the one ancestor
// RAM port; the finish pass visits the stored nodes one at a time through
// the node RAM port.
// One word is in flight at a time.
// Reset: after rst_n rises, the node RAM is swept clear, all 2**NODE_BITS
// entries, one entry per cycle, with busy high throughout.
// ----------------------------------------------------------------------------
module tree_path_load_lca_engine_unit
    import tple_pkg::*;
#(
    parameter int NODE_BITS   = NODE_BITS_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [IN_NODE_W-1:0] node_a,
    input  logic [IN_NODE_W-1:0] node_b,
    output logic                 done,
    output logic [IN_NODE_W-1:0] ancestor_node,
    output logic [LOAD_W-1:0]    max_load,
    output logic                 status
);

    localparam int NB       = NODE_BITS;
    localparam int LB       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int CW       = NB + 1;
    localparam int SLOTS    = 1 << NB;
    localparam int REC_W    = NB + LOAD_W + 1;
    localparam int ANC_D    = 1 << (NB + LB);
    localparam logic [LB-1:0] LVL_TOP = LB'(LIFT_LEVELS - 1);

    // node RAM: {present, depth, count}
    logic              n_we;
    logic [NB-1:0]     n_addr;
    logic [REC_W-1:0]  n_wdata, n_rdata;
    logic              x_we;
    logic [NB+LB-1:0]  x_addr;
    logic [NB-1:0]     x_wdata, x_rdata;
    logic              o_we;
    logic [NB-1:0]     o_addr, o_wdata, o_rdata;

    tple_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_node_ram (
        .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
    );
    tple_ram #(.WIDTH(NB), .DEPTH(ANC_D)) u_anc_ram (
        .clk(clk), .we(x_we), .addr(x_addr), .wdata(x_wdata), .rdata(x_rdata)
    );
    tple_ram #(.WIDTH(NB), .DEPTH(SLOTS)) u_order_ram (
        .clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wdata), .rdata(o_rdata)
    );

    state_t              state_reg, state_next;
    logic [NB-1:0]       clr_reg, clr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       k_reg, k_next;
    logic                done_reg, done_next;
    req_t                type_reg, type_next;
    logic [NB-1:0]       a_reg, a_next, b_reg, b_next;
    logic                a_ok_reg, a_ok_next, b_ok_reg, b_ok_next;
    logic                pres_a_reg, pres_a_next;
    logic [NB-1:0]       dep_a_reg, dep_a_next;
    logic [NB-1:0]       u_reg, u_next, v_reg, v_next, diff_reg, diff_next;
    logic [NB-1:0]       p_reg, p_next, pp_reg, pp_next, ancu_reg, ancu_next;
    logic [NB-1:0]       cur_reg, cur_next, x_reg, x_next, par_reg, par_next;
    logic [LB-1:0]       lvl_reg, lvl_next;
    logic [1:0]          j_reg, j_next;
    logic [LOAD_W-1:0]   c_reg, c_next, max_reg, max_next;
    logic [IN_NODE_W-1:0] anc_out_reg, anc_out_next;
    logic [LOAD_W-1:0]   load_out_reg, load_out_next;
    logic                status_reg, status_next;
    logic                anc_zero_reg;

    logic [NB-1:0]       anc_val, tgt, dep_b;
    logic [LOAD_W-1:0]   step;
    logic                pres_b, bad_add;

    assign anc_val = anc_zero_reg ? '0 : x_rdata;
    assign dep_b   = n_rdata[LOAD_W +: NB];
    assign pres_b  = n_rdata[REC_W-1];
    assign step    = LOAD_W'(1) << lvl_reg;

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign ancestor_node = anc_out_reg;
    assign max_load      = load_out_reg;
    assign status        = status_reg;

    always_comb
    begin
        unique case (j_reg)
            2'd0:    tgt = a_reg;
            2'd1:    tgt = b_reg;
            2'd2:    tgt = p_reg;
            default: tgt = pp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        type_reg     <= type_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        a_ok_reg     <= a_ok_next;
        b_ok_reg     <= b_ok_next;
        pres_a_reg   <= pres_a_next;
        dep_a_reg    <= dep_a_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        diff_reg     <= diff_next;
        p_reg        <= p_next;
        pp_reg       <= pp_next;
        ancu_reg     <= ancu_next;
        cur_reg      <= cur_next;
        x_reg        <= x_next;
        par_reg      <= par_next;
        lvl_reg      <= lvl_next;
        j_reg        <= j_next;
        c_reg        <= c_next;
        max_reg      <= max_next;
        anc_out_reg  <= anc_out_next;
        load_out_reg <= load_out_next;
        status_reg   <= status_next;
        anc_zero_reg <= (x_addr[NB+LB-1:LB] == '0);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        done_next     = 1'b0;
        type_next     = type_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        a_ok_next     = a_ok_reg;
        b_ok_next     = b_ok_reg;
        pres_a_next   = pres_a_reg;
        dep_a_next    = dep_a_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        diff_next     = diff_reg;
        p_next        = p_reg;
        pp_next       = pp_reg;
        ancu_next     = ancu_reg;
        cur_next      = cur_reg;
        x_next        = x_reg;
        par_next      = par_reg;
        lvl_next      = lvl_reg;
        j_next        = j_reg;
        c_next        = c_reg;
        max_next      = max_reg;
        anc_out_next  = anc_out_reg;
        load_out_next = load_out_reg;
        status_next   = status_reg;
        n_we          = 1'b0;
        n_addr        = a_reg;
        n_wdata       = n_rdata;
        x_we          = 1'b0;
        x_addr        = {u_reg, lvl_reg};
        x_wdata       = anc_val;
        o_we          = 1'b0;
        o_addr        = k_reg[NB-1:0];
        o_wdata       = a_reg;
        bad_add       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                n_we     = 1'b1;
                n_addr   = clr_reg;
                n_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    type_next = req_t'(req_type);
                    a_next    = NB'(node_a);
                    b_next    = NB'(node_b);
                    a_ok_next = (node_a != '0) && ((LOAD_W'(node_a) >> NB) == '0);
                    b_ok_next = (node_b != '0) && ((LOAD_W'(node_b) >> NB) == '0);
                    unique case (req_t'(req_type))
                        REQ_ADD, REQ_PATH:
                        begin
                            state_next = ST_RA;
                        end
                        REQ_FIN:
                        begin
                            k_next     = cnt_reg;
                            state_next = ST_F_R0;
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            anc_out_next  = '0;
                            load_out_next = '0;
                            status_next   = STS_BAD;
                        end
                    endcase
                end
            end

            ST_RA:
            begin
                n_addr     = a_reg;
                state_next = ST_RB;
            end

            ST_RB:
            begin
                n_addr      = b_reg;
                pres_a_next = n_rdata[REC_W-1];
                dep_a_next  = n_rdata[LOAD_W +: NB];
                state_next  = (type_reg == REQ_ADD) ? ST_ADD_CHK : ST_P_CHK;
            end

            ST_ADD_CHK:
            begin
                bad_add = !a_ok_reg || pres_a_reg || ((b_reg != '0) && !(b_ok_reg && pres_b))
                          || (cnt_reg >= CW'(SLOTS - 1));
                if (bad_add)
                begin
                    done_next     = 1'b1;
                    anc_out_next  = '0;
                    load_out_next = '0;
                    status_next   = STS_BAD;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    n_we       = 1'b1;
                    n_addr     = a_reg;
                    n_wdata    = {1'b1, dep_b + 1'b1, LOAD_W'(0)};
                    x_we       = 1'b1;
                    x_addr     = {a_reg, LB'(0)};
                    x_wdata    = b_reg;
                    o_we       = 1'b1;
                    o_addr     = cnt_reg[NB-1:0];
                    o_wdata    = a_reg;
                    cur_next   = b_reg;
                    lvl_next   = LB'(1);
                    state_next = ST_ADD_LR;
                end
            end

            ST_ADD_LR:
            begin
                x_addr     = {cur_reg, lvl_reg - 1'b1};
                state_next = ST_ADD_LW;
            end

            ST_ADD_LW:
            begin
                x_we     = 1'b1;
                x_addr   = {a_reg, lvl_reg};
                x_wdata  = anc_val;
                cur_next = anc_val;
                if (lvl_reg == LVL_TOP)
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    done_next     = 1'b1;
                    anc_out_next  = '0;
                    load_out_next = '0;
                    status_next   = STS_OK;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = ST_ADD_LR;
                end
            end

            ST_P_CHK:
            begin
                if (!(a_ok_reg && pres_a_reg && b_ok_reg && pres_b))
                begin
                    done_next     = 1'b1;
                    anc_out_next  = '0;
                    load_out_next = '0;
                    status_next   = STS_BAD;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    if (dep_a_reg < dep_b)
                    begin
                        u_next    = b_reg;
                        v_next    = a_reg;
                        diff_next = dep_b - dep_a_reg;
                    end
                    else
                    begin
                        u_next    = a_reg;
                        v_next    = b_reg;
                        diff_next = dep_a_reg - dep_b;
                    end
                    lvl_next   = LVL_TOP;
                    state_next = ST_P_L1;
                end
            end

            ST_P_L1:
            begin
                if (LOAD_W'(diff_reg) >= step)
                begin
                    x_addr     = {u_reg, lvl_reg};
                    state_next = ST_P_L1W;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_P_EQ;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end

            ST_P_L1W:
            begin
                u_next    = anc_val;
                diff_next = diff_reg - NB'(step);
                if (lvl_reg == '0)
                begin
                    state_next = ST_P_EQ;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_P_L1;
                end
            end

            ST_P_EQ:
            begin
                if (u_reg == v_reg)
                begin
                    p_next     = u_reg;
                    state_next = ST_P_PP;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = ST_P_L2A;
                end
            end

            ST_P_L2A:
            begin
                x_addr     = {u_reg, lvl_reg};
                state_next = ST_P_L2B;
            end

            ST_P_L2B:
            begin
                x_addr     = {v_reg, lvl_reg};
                ancu_next  = anc_val;
                state_next = ST_P_L2C;
            end

            ST_P_L2C:
            begin
                if (ancu_reg != anc_val)
                begin
                    u_next = ancu_reg;
                    v_next = anc_val;
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_P_L2F;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_P_L2A;
                end
            end

            ST_P_L2F:
            begin
                x_addr     = {u_reg, LB'(0)};
                state_next = ST_P_L2G;
            end

            ST_P_L2G:
            begin
                p_next     = anc_val;
                state_next = ST_P_PP;
            end

            ST_P_PP:
            begin
                x_addr     = {p_reg, LB'(0)};
                state_next = ST_P_PPW;
            end

            ST_P_PPW:
            begin
                pp_next    = anc_val;
                j_next     = 2'd0;
                state_next = ST_P_UR;
            end

            ST_P_UR:
            begin
                n_addr     = tgt;
                state_next = ST_P_UW;
            end

            ST_P_UW:
            begin
                n_we    = 1'b1;
                n_addr  = tgt;
                n_wdata = {n_rdata[REC_W-1:LOAD_W],
                           (j_reg[1] ? n_rdata[LOAD_W-1:0] - 1'b1
                                     : n_rdata[LOAD_W-1:0] + 1'b1)};
                if (j_reg == 2'd3)
                begin
                    done_next     = 1'b1;
                    anc_out_next  = IN_NODE_W'(p_reg);
                    load_out_next = '0;
                    status_next   = STS_OK;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_P_UR;
                end
            end

            ST_F_R0:
            begin
                if (k_reg == '0)
                begin
                    max_next   = '0;
                    state_next = ST_G_R;
                end
                else
                begin
                    o_addr     = NB'(k_reg - 1'b1);
                    k_next     = k_reg - 1'b1;
                    state_next = ST_F_X;
                end
            end

            ST_F_X:
            begin
                x_addr     = {o_rdata, LB'(0)};
                n_addr     = o_rdata;
                state_next = ST_F_C;
            end

            ST_F_C:
            begin
                c_next     = n_rdata[LOAD_W-1:0];
                par_next   = anc_val;
                n_addr     = anc_val;
                state_next = ST_F_W;
            end

            ST_F_W:
            begin
                n_we       = 1'b1;
                n_addr     = par_reg;
                n_wdata    = {n_rdata[REC_W-1:LOAD_W], n_rdata[LOAD_W-1:0] + c_reg};
                state_next = ST_F_R0;
            end

            ST_G_R:
            begin
                if (k_reg == cnt_reg)
                begin
                    done_next     = 1'b1;
                    anc_out_next  = '0;
                    load_out_next = max_reg;
                    status_next   = STS_OK;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    o_addr     = k_reg[NB-1:0];
                    state_next = ST_G_X;
                end
            end

            ST_G_X:
            begin
                n_addr     = o_rdata;
                x_next     = o_rdata;
                state_next = ST_G_W;
            end

            ST_G_W:
            begin
                if (n_rdata[LOAD_W-1:0] > max_reg)
                begin
                    max_next = n_rdata[LOAD_W-1:0];
                end
                n_we       = 1'b1;
                n_addr     = x_reg;
                n_wdata    = {n_rdata[REC_W-1:LOAD_W], LOAD_W'(0)};
                k_next     = k_reg + 1'b1;
                state_next = ST_G_R;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/tple_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tple_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tple_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
